// ===== design/pic_pkg.sv =====
// Shared constants and types for the palette interpolating colorizer.
package pic_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int FRAC_BITS     = 8;

    localparam int IDX_W    = $clog2(PALETTE_DEPTH);
    localparam int COLOR_W  = 24;
    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 3;
    localparam int WEIGHT_W = FRAC_BITS + 1;
    localparam int PROD_W   = CHAN_W + WEIGHT_W;
    localparam int PIXEL_W  = 32;
    localparam int S_DATA_W = 64;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hff;
    localparam logic [WEIGHT_W-1:0] FRAC_ONE  = WEIGHT_W'(1) << FRAC_BITS;

    // request kinds carried on s_tuser
    localparam logic REQ_WRITE    = 1'b0;
    localparam logic REQ_COLORIZE = 1'b1;

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [COLOR_W-1:0]   color_t;
    typedef logic [FRAC_BITS-1:0] frac_t;

    // fetch stage output: pixel meta plus both palette entries
    typedef struct packed {
        logic   valid;
        logic   no_value;
        frac_t  frac;
        color_t c_lo;
        color_t c_hi;
    } fetch_t;

endpackage

// ===== design/pic_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/pic_fetch.sv =====
// Input stage: palette writes and the two palette reads for each pixel.
module pic_fetch
    import pic_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         req_type,
    input  logic [7:0]   palette_index,
    input  color_t       palette_color,
    input  logic [15:0]  value_int,
    input  logic [7:0]   value_frac,
    input  logic         no_value,
    input  logic         out_ready,
    output fetch_t       fetch
);

    logic   valid_reg, valid_next;
    logic   no_value_reg;
    frac_t  frac_reg;
    logic   accept;
    logic   wr_en;
    logic   rd_en;
    idx_t   wr_addr;
    idx_t   rd_addr_lo;
    idx_t   rd_addr_hi;
    color_t c_lo;
    color_t c_hi;

    // stage holds while a pixel waits for the blend stage
    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign wr_en    = accept && (req_type == REQ_WRITE);
    assign rd_en    = accept && (req_type == REQ_COLORIZE);

    assign wr_addr    = idx_t'(palette_index);
    assign rd_addr_lo = idx_t'(value_int);
    assign rd_addr_hi = rd_addr_lo + idx_t'(1);

    // both copies take every write so each serves one read address
    pic_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_ram_lo (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (palette_color),
        .re    (rd_en),
        .raddr (rd_addr_lo),
        .rdata (c_lo)
    );

    pic_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_ram_hi (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (palette_color),
        .re    (rd_en),
        .raddr (rd_addr_hi),
        .rdata (c_hi)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = rd_en;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            frac_reg     <= frac_t'(value_frac);
            no_value_reg <= no_value;
        end
    end

    assign fetch.valid    = valid_reg;
    assign fetch.no_value = no_value_reg;
    assign fetch.frac     = frac_reg;
    assign fetch.c_lo     = c_lo;
    assign fetch.c_hi     = c_hi;

endmodule

// ===== design/pic_blend.sv =====
// Blend stages: weighted channel products, then sum, shift and output register.
module pic_blend
    import pic_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  fetch_t             fetch,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PIXEL_W-1:0] pixel_argb
);

    logic                  mul_valid_reg, mul_valid_next;
    logic                  mul_no_value_reg;
    logic [PROD_W-1:0]     prod_lo_reg [NUM_CHAN];
    logic [PROD_W-1:0]     prod_hi_reg [NUM_CHAN];
    logic                  out_valid_reg, out_valid_next;
    logic [PIXEL_W-1:0]    pixel_reg;
    logic [PIXEL_W-1:0]    pixel_next;
    logic [WEIGHT_W-1:0]   w_lo;
    logic [WEIGHT_W-1:0]   w_hi;
    logic [CHAN_W-1:0]     chan_out [NUM_CHAN];
    logic                  mul_ready;
    logic                  mul_load;
    logic                  out_load;

    assign mul_ready = !out_valid_reg || out_ready;
    assign in_ready  = !mul_valid_reg || mul_ready;
    assign mul_load  = in_ready && fetch.valid;
    assign out_load  = mul_ready && mul_valid_reg;

    assign w_hi = WEIGHT_W'(fetch.frac);
    assign w_lo = FRAC_ONE - w_hi;

    for (genvar ch = 0; ch < NUM_CHAN; ch++)
    begin : g_chan
        logic [CHAN_W-1:0] a;
        logic [CHAN_W-1:0] b;
        logic [PROD_W-1:0] sum;

        assign a = fetch.c_lo[ch*CHAN_W +: CHAN_W];
        assign b = fetch.c_hi[ch*CHAN_W +: CHAN_W];

        always_ff @(posedge clk)
        begin
            if (mul_load)
            begin
                prod_lo_reg[ch] <= PROD_W'(a) * PROD_W'(w_lo);
                prod_hi_reg[ch] <= PROD_W'(b) * PROD_W'(w_hi);
            end
        end

        // sum never exceeds 255 << FRAC_BITS, so the shifted value fits a byte
        assign sum          = prod_lo_reg[ch] + prod_hi_reg[ch];
        assign chan_out[ch] = CHAN_W'(sum >> FRAC_BITS);
    end

    always_comb
    begin
        mul_valid_next = mul_valid_reg;
        if (in_ready)
        begin
            mul_valid_next = fetch.valid;
        end
        out_valid_next = out_valid_reg;
        if (mul_ready)
        begin
            out_valid_next = mul_valid_reg;
        end
        if (mul_no_value_reg)
        begin
            pixel_next = '0;
        end
        else
        begin
            pixel_next = {ALPHA_OPAQUE, chan_out[2], chan_out[1], chan_out[0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= mul_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_load)
        begin
            mul_no_value_reg <= fetch.no_value;
        end
        if (out_load)
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_argb = pixel_reg;

endmodule

// ===== design/palette_interpolating_colorizer.sv =====
// m_tvalid follows an s-side pixel through the fetch register, the product register and the output register.
// Throughput: one transfer per cycle, palette writes and pixels alike; each stage
// holds only while the stage after it is full and stalled.
// Palette writes return nothing. Two mirrored palette RAMs serve entries i and i+1.
// Reset (rst_n low, asynchronous) empties the pipeline; palette contents are kept.
module palette_interpolating_colorizer
    import pic_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [7:0] palette_index, [31:8] palette_color, [47:32] value_int,
    // [55:48] value_frac, [56] no_value, [63:57] zero
    input  logic [S_DATA_W-1:0] s_tdata,
    // [0] req_type
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [31:0] pixel_argb
    output logic [PIXEL_W-1:0]  m_tdata
);

    fetch_t fetch;
    logic   blend_ready;

    pic_fetch u_fetch (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .req_type      (s_tuser),
        .palette_index (s_tdata[7:0]),
        .palette_color (s_tdata[31:8]),
        .value_int     (s_tdata[47:32]),
        .value_frac    (s_tdata[55:48]),
        .no_value      (s_tdata[56]),
        .out_ready     (blend_ready),
        .fetch         (fetch)
    );

    pic_blend u_blend (
        .clk        (clk),
        .rst_n      (rst_n),
        .fetch      (fetch),
        .in_ready   (blend_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .pixel_argb (m_tdata)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the palette interpolating colorizer: palette writes and pixel lookups.
module tb_top;
    import pic_pkg::*;

    localparam int DUT_LAT     = 3;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASE_ITEMS = 425;

    // one stream item as the sender offers it, with an optional typed-in result
    typedef struct packed {
        logic                req;
        logic [7:0]          idx;
        color_t              color;
        logic [15:0]         vint;
        logic [7:0]          frac;
        logic                nov;
        logic                known;
        logic [PIXEL_W-1:0]  px;
    } pic_item_t;

    localparam int DIR_ROWS = 16;
    localparam pic_item_t DIR_TBL [DIR_ROWS] = '{
        '{REQ_WRITE,    8'h00, 24'h000000, 16'h0000, 8'h00, 1'b0, 1'b0, 32'h0},
        // ignored pixel fields all ones on a write
        '{REQ_WRITE,    8'hff, 24'hffffff, 16'hffff, 8'hff, 1'b1, 1'b0, 32'h0},
        '{REQ_WRITE,    8'h01, 24'hffffff, 16'h0000, 8'h00, 1'b0, 1'b0, 32'h0},
        '{REQ_COLORIZE, 8'h00, 24'h000000, 16'h0000, 8'h00, 1'b0, 1'b1, 32'hff000000},
        '{REQ_COLORIZE, 8'hff, 24'hffffff, 16'h0000, 8'hff, 1'b0, 1'b1, 32'hfffefefe},
        // top integer part wraps to entry 0
        '{REQ_COLORIZE, 8'h00, 24'h000000, 16'hffff, 8'h00, 1'b0, 1'b1, 32'hffffffff},
        '{REQ_COLORIZE, 8'h00, 24'h000000, 16'hffff, 8'h80, 1'b0, 1'b1, 32'hff7f7f7f},
        // no value: transparent black regardless of the rest
        '{REQ_COLORIZE, 8'hff, 24'hffffff, 16'hffff, 8'hff, 1'b1, 1'b1, 32'h00000000},
        '{REQ_COLORIZE, 8'h00, 24'h000000, 16'h0000, 8'h00, 1'b1, 1'b1, 32'h00000000},
        '{REQ_WRITE,    8'h02, 24'h123456, 16'h0000, 8'h00, 1'b0, 1'b0, 32'h0},
        '{REQ_WRITE,    8'h03, 24'hff00aa, 16'h0000, 8'h00, 1'b0, 1'b0, 32'h0},
        '{REQ_COLORIZE, 8'h00, 24'h000000, 16'h0002, 8'h40, 1'b0, 1'b0, 32'h0},
        '{REQ_COLORIZE, 8'h00, 24'h000000, 16'hab02, 8'h80, 1'b0, 1'b0, 32'h0},
        '{REQ_COLORIZE, 8'h00, 24'h000000, 16'h0101, 8'hff, 1'b0, 1'b0, 32'h0},
        // overwrite the last entry, then blend across the wrap
        '{REQ_WRITE,    8'hff, 24'h80ff01, 16'h0000, 8'h00, 1'b0, 1'b0, 32'h0},
        '{REQ_COLORIZE, 8'h00, 24'h000000, 16'h00ff, 8'h01, 1'b0, 1'b0, 32'h0}
    };

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [PIXEL_W-1:0]  m_tdata;

    color_t             pal_shadow [PALETTE_DEPTH];
    bit                 pal_written [PALETTE_DEPTH];
    logic [PIXEL_W-1:0] argb_expect_q [$];
    int                 err_cnt;
    int                 tx_idle_pct;
    int                 rx_stall_pct;
    bit                 rx_hold_req;

    palette_interpolating_colorizer i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("Test completed with failures");
        $finish;
    end

    // expected ARGB for one pixel, from the shadow palette
    function automatic logic [PIXEL_W-1:0] colorize_pixel(input logic [15:0] vint,
                                                          input logic [7:0] frac,
                                                          input logic nov);
        color_t             lo;
        color_t             hi;
        int                 f;
        int                 acc;
        logic [PIXEL_W-1:0] argb;
        if (nov)
            return '0;
        lo = pal_shadow[idx_t'(vint)];
        hi = pal_shadow[idx_t'(vint + 16'd1)];
        f  = int'(frac_t'(frac));
        argb = '0;
        argb[PIXEL_W-1 -: CHAN_W] = ALPHA_OPAQUE;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            acc = int'(lo[c*CHAN_W +: CHAN_W]) * (int'(FRAC_ONE) - f)
                + int'(hi[c*CHAN_W +: CHAN_W]) * f;
            argb[c*CHAN_W +: CHAN_W] = CHAN_W'(acc >> FRAC_BITS);
        end
        return argb;
    endfunction

    // offer one item, wait for the transfer, then update the shadow state
    task automatic send_item(input pic_item_t it);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.req;
        s_tdata  <= {7'b0, it.nov, it.frac, it.vint, it.color, it.idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (it.req == REQ_WRITE)
        begin
            pal_shadow[idx_t'(it.idx)]  = it.color;
            pal_written[idx_t'(it.idx)] = 1'b1;
        end
        else
            argb_expect_q = {argb_expect_q,
                             (it.known ? it.px : colorize_pixel(it.vint, it.frac, it.nov))};
    endtask

    // random item; pixels only land on entry pairs that have been written
    task automatic make_random_item(output pic_item_t it);
        idx_t probe;
        bit   found;
        it       = '0;
        it.idx   = 8'($urandom);
        it.color = 24'($urandom);
        it.vint  = 16'($urandom);
        it.frac  = 8'($urandom);
        case ($urandom_range(7))
            0: it.frac = 8'h00;
            1: it.frac = 8'hff;
            default: ;
        endcase
        if ($urandom_range(99) < 25)
        begin
            it.req = REQ_WRITE;
            it.nov = 1'($urandom);
            return;
        end
        it.req = REQ_COLORIZE;
        if ($urandom_range(9) == 0)
        begin
            it.nov = 1'b1;
            return;
        end
        found = 1'b0;
        for (int t = 0; t < 8 && !found; t++)
        begin
            probe = idx_t'($urandom);
            found = pal_written[probe] && pal_written[idx_t'(probe + 1'b1)];
        end
        if (found)
            it.vint[IDX_W-1:0] = probe;
        else
            it.req = REQ_WRITE;
    endtask

    // stop offering and let every pending pixel come out
    task automatic wait_all_pixels();
        s_tvalid <= 1'b0;
        while (argb_expect_q.size() != 0)
            @(posedge clk);
        repeat (DUT_LAT + 2) @(posedge clk);
    endtask

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        logic [PIXEL_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (argb_expect_q.size() == 0)
            begin
                $display("%0t: unexpected pixel_argb: expected none, got %08h", $time, m_tdata);
                err_cnt++;
            end
            else
            begin
                want = argb_expect_q.pop_front();
                if (m_tdata !== want)
                begin
                    $display("%0t: pixel_argb mismatch: expected %08h, got %08h",
                             $time, want, m_tdata);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin
        pic_item_t it;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        rst_n        = 1'b0;
        err_cnt      = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_req  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < DIR_ROWS; k++)
            send_item(DIR_TBL[k]);
        wait_all_pixels();

        // phases: no idling, sender idle, receiver stalls, both
        for (int ph = 0; ph < 4; ph++)
        begin
            tx_idle_pct  = (ph == 1) ? 68 : (ph == 3) ? 22 : 0;
            rx_stall_pct = (ph == 2) ? 68 : (ph == 3) ? 22 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // long receiver hold-off while the sender keeps going: fills the pipe
                if (ph == 0 && n == 150)
                    rx_hold_req = 1'b1;
                make_random_item(it);
                send_item(it);
            end
            wait_all_pixels();
        end

        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/pic_pkg.sv
design/pic_ram.sv
design/pic_fetch.sv
design/pic_blend.sv
design/palette_interpolating_colorizer.sv
tb/sv/tb_top.sv
